>>> sv/ngi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ngi_pkg
// shared types and constants for the gga to igc b record builder
// ----------------------------------------------------------------------------
package ngi_pkg;

    // ascii characters
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // sentence field numbers, time is the first
    localparam logic [3:0] FIELD_TIME  = 4'd1;
    localparam logic [3:0] FIELD_LAT   = 4'd2;
    localparam logic [3:0] FIELD_NS    = 4'd3;
    localparam logic [3:0] FIELD_LON   = 4'd4;
    localparam logic [3:0] FIELD_EW    = 4'd5;
    localparam logic [3:0] FIELD_FIX   = 4'd7;
    localparam logic [3:0] FIELD_BARO  = 4'd8;
    localparam logic [3:0] FIELD_GALT  = 4'd9;
    localparam logic [3:0] FIELD_ALTO  = 4'd10;
    localparam logic [3:0] FIELD_END   = 4'd11;
    localparam logic [3:0] FIELD_MAX   = 4'd15;

    localparam logic [3:0] CARD_DIGITS = 4'd1;

    // queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        OP_START      = 4'd0,
        OP_CHAR       = 4'd1,
        OP_FIX        = 4'd2,
        OP_ALTI       = 4'd3,
        OP_STORE      = 4'd4,
        OP_ALIGN      = 4'd5,
        OP_ALIGN_EMIT = 4'd6,
        OP_CRLF       = 4'd7
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] data;   // character or clamped baro altitude
        logic [3:0]  arg;    // store slot or align shift
    } op_t;

endpackage
`default_nettype wire

>>> sv/ngi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ngi_front
// sentence field tracker, turns transfers into back-end operations where one is needed
// ----------------------------------------------------------------------------
module ngi_front #(
    parameter int TIME_DIGITS = 6,
    parameter int LAT_DIGITS  = 7,
    parameter int LON_DIGITS  = 8,
    parameter int ALT_DIGITS  = 5
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire logic          cmd,
    input  wire logic [7:0]    char_in,
    input  wire logic [16:0]   baro_alti,
    output ngi_pkg::op_t       op,
    output logic               op_valid
);
    import ngi_pkg::*;

    logic [3:0] field_count_reg, field_count_next;
    logic [3:0] digits_left_reg, digits_left_next;
    logic [3:0] fc_inc;
    logic [3:0] shift;

    assign fc_inc = (field_count_reg == FIELD_MAX) ? FIELD_MAX : field_count_reg + 4'd1;
    assign shift  = (digits_left_reg > 4'(ALT_DIGITS)) ? 4'(ALT_DIGITS) : digits_left_reg;

    always_comb begin
        field_count_next = field_count_reg;
        digits_left_next = digits_left_reg;
        op_valid         = 1'b0;
        op.kind          = OP_CHAR;
        op.data          = {8'h00, char_in};
        op.arg           = shift;
        if (cmd == 1'b0) begin
            field_count_next = FIELD_TIME;
            digits_left_next = 4'(TIME_DIGITS);
            op_valid         = 1'b1;
            op.kind          = OP_START;
            op.data          = baro_alti[16] ? 16'h0000 : baro_alti[15:0];
        end else if (char_in == CH_COMMA) begin
            field_count_next = fc_inc;
            digits_left_next = 4'd0;
            case (fc_inc)
                FIELD_LAT: digits_left_next = 4'(LAT_DIGITS);
                FIELD_NS, FIELD_EW: digits_left_next = CARD_DIGITS;
                FIELD_LON: digits_left_next = 4'(LON_DIGITS);
                FIELD_FIX: begin
                    op_valid = 1'b1;
                    op.kind  = OP_FIX;
                end
                FIELD_BARO: begin
                    op_valid = 1'b1;
                    op.kind  = OP_ALTI;
                end
                FIELD_GALT: digits_left_next = 4'(ALT_DIGITS);
                FIELD_ALTO: begin
                    op_valid = 1'b1;
                    op.kind  = OP_ALIGN_EMIT;
                end
                FIELD_END: begin
                    op_valid = 1'b1;
                    op.kind  = OP_CRLF;
                end
                default: digits_left_next = 4'd0;
            endcase
        end else if (field_count_reg == FIELD_GALT) begin
            if (char_in == CH_DOT) begin
                digits_left_next = 4'd0;
                op_valid         = 1'b1;
                op.kind          = OP_ALIGN;
            end else if (digits_left_reg != 4'd0 && digits_left_reg <= 4'(ALT_DIGITS)) begin
                digits_left_next = digits_left_reg - 4'd1;
                op_valid         = 1'b1;
                op.kind          = OP_STORE;
                op.arg           = digits_left_reg - 4'd1;
            end
        end else if (field_count_reg < FIELD_BARO && char_in != CH_DOT
                     && digits_left_reg != 4'd0) begin
            digits_left_next = digits_left_reg - 4'd1;
            op_valid         = 1'b1;
            op.kind          = OP_CHAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_count_reg <= 4'd0;
            digits_left_reg <= 4'd0;
        end else if (accept) begin
            field_count_reg <= field_count_next;
            digits_left_reg <= digits_left_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/ngi_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ngi_queue
// short operation queue between the field tracker and the emitter
// ----------------------------------------------------------------------------
module ngi_queue (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  ngi_pkg::op_t  push_op,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output ngi_pkg::op_t  head_op
);
    import ngi_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    op_t              slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slots_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/ngi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ngi_back
// operation sequencer: altitude digit store, baro conversion, record output
// ----------------------------------------------------------------------------
module ngi_back #(
    parameter int ALT_DIGITS = 5
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        head_valid,
    input  ngi_pkg::op_t     head_op,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_char_out,
    output logic             m_last
);
    import ngi_pkg::*;

    localparam int ALT_W  = ALT_DIGITS * 8;
    localparam int STEP_W = $clog2(ALT_DIGITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ALT_DIGITS - 1);

    logic              cur_valid_reg, cur_valid_next;
    op_t               cur_op_reg, cur_op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [15:0]       work_reg, work_next;
    logic [ALT_W-1:0]  alti_reg, alti_next;
    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              out_last_reg;

    logic              out_free, emit, emit_last, done, advance, load;
    logic [7:0]        emit_char;
    logic [7:0]        alti_byte;
    logic [31:0]       product;
    logic [15:0]       quot, rem;
    logic [ALT_W-1:0]  aligned;
    logic [ALT_W-1:0]  fill_mask;

    assign out_free = !out_valid_reg || m_ready;

    // divide by ten through reciprocal, exact for 16-bit values
    assign product = {16'h0000, work_reg} * 32'd52429;
    assign quot    = {3'b000, product[31:19]};
    assign rem     = work_reg - ((quot << 3) + (quot << 1));

    assign fill_mask = ~({ALT_W{1'b1}} >> {cur_op_reg.arg, 3'b000});
    assign aligned   = (alti_reg >> {cur_op_reg.arg, 3'b000})
                     | (fill_mask & {ALT_DIGITS{CH_ZERO}});

    // most significant digit first
    always_comb begin
        alti_byte = CH_ZERO;
        for (int i = 0; i < ALT_DIGITS; i++) begin
            if (STEP_W'(ALT_DIGITS - 1 - i) == step_reg) begin
                alti_byte = alti_reg[i*8 +: 8];
            end
        end
    end

    always_comb begin
        emit        = 1'b0;
        emit_last   = 1'b0;
        emit_char   = cur_op_reg.data[7:0];
        done        = 1'b0;
        advance     = 1'b0;
        alti_next   = alti_reg;
        work_next   = work_reg;
        cur_op_next = cur_op_reg;
        if (cur_valid_reg) begin
            case (cur_op_reg.kind)
                OP_CHAR: begin
                    emit      = out_free;
                    emit_last = 1'b1;
                    done      = out_free;
                end
                OP_FIX: begin
                    emit      = out_free;
                    emit_char = CH_A;
                    emit_last = 1'b1;
                    done      = out_free;
                end
                OP_CRLF: begin
                    emit      = out_free;
                    emit_char = (step_reg == '0) ? CH_CR : CH_LF;
                    emit_last = (step_reg != '0);
                    done      = out_free && (step_reg != '0);
                    advance   = out_free;
                end
                OP_ALTI: begin
                    emit      = out_free;
                    emit_char = alti_byte;
                    emit_last = (step_reg == STEP_LAST);
                    done      = out_free && (step_reg == STEP_LAST);
                    advance   = out_free;
                end
                OP_START: begin
                    advance   = (step_reg != STEP_LAST) || out_free;
                    emit      = (step_reg == STEP_LAST) && out_free;
                    emit_char = CH_B;
                    emit_last = 1'b1;
                    done      = emit;
                    if (advance) begin
                        work_next = quot;
                        for (int i = 0; i < ALT_DIGITS; i++) begin
                            if (STEP_W'(i) == step_reg) begin
                                alti_next[i*8 +: 8] = CH_ZERO | {4'h0, rem[3:0]};
                            end
                        end
                    end
                end
                OP_STORE: begin
                    done = 1'b1;
                    for (int i = 0; i < ALT_DIGITS; i++) begin
                        if (4'(i) == cur_op_reg.arg) begin
                            alti_next[i*8 +: 8] = cur_op_reg.data[7:0];
                        end
                    end
                end
                OP_ALIGN: begin
                    done      = 1'b1;
                    alti_next = aligned;
                end
                OP_ALIGN_EMIT: begin
                    // align now, then emit as a plain digit dump
                    alti_next        = aligned;
                    cur_op_next.kind = OP_ALTI;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end
        // a finished or idle emitter takes the next queued operation
        if ((!cur_valid_reg || done) && head_valid) begin
            cur_op_next = head_op;
            work_next   = head_op.data;
        end
    end

    assign load = (!cur_valid_reg || done) && head_valid;
    assign pop  = load;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (load) begin
            cur_valid_next = 1'b1;
            step_next      = '0;
        end else if (done) begin
            cur_valid_next = 1'b0;
        end else if (advance) begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            alti_reg      <= {ALT_DIGITS{CH_ZERO}};
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            alti_reg      <= alti_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_op_reg <= cur_op_next;
        work_reg   <= work_next;
        if (emit) begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_char_out = out_char_reg;
    assign m_last     = out_last_reg;

endmodule
`default_nettype wire

>>> sv/nmea_gga_to_igc_b_record.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_gga_to_igc_b_record
// builds one igc b fix record from a baro altitude and a gga sentence
// ----------------------------------------------------------------------------
// usage
//   input channel (s_): s_cmd = 0 starts a record with s_baro_alti (negative
//   clamps to zero), s_cmd = 1 feeds one gga character from just after the tag
//   result channel (m_): one record character per transfer, m_last marks the
//   final character caused by one input transfer
// path and throughput
//   a field character or comma that emits one character passes through the
//   queue slot, the current operation register and the output register; one
//   input transfer per cycle is taken while the operation queue has room
//   a start item converts ALT_DIGITS decimal digits, one digit per cycle
//   from the reciprocal divide-by-ten unit, the last when output is free;
//   the baro and gps altitude dumps emit ALT_DIGITS characters, the gps dump
//   after a right-alignment step, and cr lf emits a cr and then an lf
// reset
//   field tracker returns to no field, altitude digits read as ascii zero,
//   queue and output register empty
// stalls
//   when m_ready is low the output register holds, the emitter waits at
//   its next character, the queue fills; s_ready drops only once full
// ----------------------------------------------------------------------------
module nmea_gga_to_igc_b_record #(
    parameter int TIME_DIGITS = 6,
    parameter int LAT_DIGITS  = 7,
    parameter int LON_DIGITS  = 8,
    parameter int ALT_DIGITS  = 5
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_cmd,
    input  wire logic [7:0]         s_char_in,
    input  wire logic signed [16:0] s_baro_alti,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_char_out,
    output logic                    m_last
);
    import ngi_pkg::*;

    logic  accept;
    logic  q_full;
    logic  front_valid;
    op_t   front_op;
    logic  q_pop;
    logic  q_valid;
    op_t   q_head;

    // a transfer is taken whenever the queue can hold its operation
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // field tracking and classification
    ngi_front #(
        .TIME_DIGITS (TIME_DIGITS),
        .LAT_DIGITS  (LAT_DIGITS),
        .LON_DIGITS  (LON_DIGITS),
        .ALT_DIGITS  (ALT_DIGITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (s_cmd),
        .char_in   (s_char_in),
        .baro_alti (s_baro_alti),
        .op        (front_op),
        .op_valid  (front_valid)
    );

    // decoupling queue, only operations that do something are pushed
    ngi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept && front_valid),
        .push_op    (front_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head)
    );

    // emitter with altitude digit store and output register
    ngi_back #(
        .ALT_DIGITS (ALT_DIGITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_op    (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_out (m_char_out),
        .m_last     (m_last)
    );

endmodule
`default_nettype wire
